// ----- src/wscx_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wscx_pkg
// Shared types, constants and the key-scheduled permutation image for the
// word stream cipher unit.
// ----------------------------------------------------------------------------
package wscx_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
  localparam int WORD_W        = 32;
  localparam int BYTE_W        = 8;
  localparam int KEY_WORDS     = 16;
  localparam int KEY_IDX_W     = $clog2(KEY_WORDS);

  localparam logic             CMD_WORD = 1'b0;
  localparam logic             CMD_BYTE = 1'b1;
  localparam logic [BYTE_W-1:0] BYTE_PAD = 8'h8D;
  localparam logic [WORD_W-1:0] INIT_NUMERATOR = 32'hFFFF_FFFF;

  typedef logic [TABLE_ENTRIES-1:0][WORD_W-1:0] wscx_rom_t;
  typedef logic [0:KEY_WORDS-1][WORD_W-1:0]     wscx_key_t;

  localparam wscx_key_t SCHED_KEY = '{
    32'hFFAA_FFAA, 32'hAAFC_AAFC, 32'hA37E_A37E, 32'hB34E_B34E,
    32'hFFFF_FFFF, 32'h3BE7_3BE7, 32'hCBA9_CBA9, 32'h23C1_23C1,
    32'h2E6C_2E6C, 32'h13CB_13CB, 32'h64E7_64E7, 32'h34D2_34D2,
    32'hFF6C_2E6C, 32'h13FF_13CB, 32'h64E7_FFE7, 32'h34D2_34FF
  };

  typedef struct packed {
    logic              clear;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
  } wscx_mem_req_t;

  // Entry k starts as all-ones over (k+1), then one key-scheduling pass.
  function automatic wscx_rom_t build_perm_rom();
    wscx_rom_t         rom;
    logic [WORD_W-1:0] quo;
    logic [WORD_W-1:0] rem_v;
    logic [WORD_W:0]   trial;
    logic [WORD_W-1:0] dvs;
    logic [ADDR_W-1:0] jj;
    logic [WORD_W-1:0] tmp;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      dvs   = WORD_W'(k + 1);
      quo   = '0;
      rem_v = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
        trial = {rem_v, INIT_NUMERATOR[b]};
        if (trial >= {1'b0, dvs}) begin
          trial  = trial - {1'b0, dvs};
          quo[b] = 1'b1;
        end
        rem_v = trial[WORD_W-1:0];
      end
      rom[k] = quo;
    end
    jj = '0;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      jj      = jj + rom[k][ADDR_W-1:0] + SCHED_KEY[KEY_IDX_W'(k)][ADDR_W-1:0];
      tmp     = rom[k];
      rom[k]  = rom[jj];
      rom[jj] = tmp;
    end
    return rom;
  endfunction

  localparam wscx_rom_t PERM_ROM = build_perm_rom();

endpackage
`default_nettype wire

// ----- src/word_stream_cipher_xor_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// word_stream_cipher_xor_unit
// RC4-like stream cipher over a 256-entry table of 32-bit words.
// ----------------------------------------------------------------------------
// Each request is a 32-bit word run through the keystream or a trailing byte
// XORed with 0x8D. A new request is held off until the last one's reads are
// done or while the output queue has no room: a word needs a read of S[i], a
// read of S[j] and a read of the keystream entry, in sequence, on the single
// read port of the table, with S[i] written back during the keystream read
// and S[j] last; the next request's first read overlaps that last write.
// Up to two results are queued when the output stalls. Start of buffer
// restores the scheduled table at once, with no clearing pass.
module word_stream_cipher_xor_unit import wscx_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_cmd,
  input  wire logic              in_start_of_buffer,
  input  wire logic [WORD_W-1:0] in_data_in,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [WORD_W-1:0]      out_data_out
);

  logic                accept;
  logic [ADDR_W-1:0]   i_r;
  logic [ADDR_W-1:0]   j_r;
  logic [ADDR_W-1:0]   i_first;
  logic [ADDR_W-1:0]   j_sum;
  logic [ADDR_W-1:0]   key_addr;
  logic [WORD_W-1:0]   mem_rd;
  wscx_mem_req_t       mem_req;

  logic                s2_v_r;
  logic                s2_cmd_r;
  logic [WORD_W-1:0]   s2_data_r;
  logic [ADDR_W-1:0]   s2_i_r;

  logic                s3_v_r;
  logic                s3_cmd_r;
  logic [WORD_W-1:0]   s3_data_r;
  logic [ADDR_W-1:0]   s3_i_r;
  logic [ADDR_W-1:0]   s3_j_r;
  logic [WORD_W-1:0]   s3_si_r;

  logic                s4_v_r;
  logic                s4_cmd_r;
  logic [WORD_W-1:0]   s4_data_r;
  logic [ADDR_W-1:0]   s4_j_r;
  logic [WORD_W-1:0]   s4_si_r;
  logic                s4_fwd_r;

  logic [WORD_W-1:0]   keystream;
  logic [WORD_W-1:0]   result;
  logic [1:0]          fifo_count;
  logic [1:0]          credit_use;
  logic                fifo_pop;

  assign credit_use = fifo_count + {1'b0, s4_v_r};
  assign in_stall   = s2_v_r | s3_v_r | (credit_use > 2'd1);
  assign accept     = in_valid & ~in_stall;

  assign i_first  = in_start_of_buffer ? ADDR_W'(1) : i_r + ADDR_W'(1);
  assign j_sum    = j_r + mem_rd[ADDR_W-1:0];
  assign key_addr = s3_si_r[ADDR_W-1:0] + mem_rd[ADDR_W-1:0];

  always_comb begin
    mem_req         = '0;
    mem_req.clear   = accept & in_start_of_buffer;
    mem_req.rd_addr = i_first;
    if (s2_v_r) begin
      mem_req.rd_addr = j_sum;
    end else if (s3_v_r) begin
      mem_req.rd_addr = key_addr;
    end
    if (s3_v_r && (s3_cmd_r == CMD_WORD)) begin
      mem_req.wr_en   = 1'b1;
      mem_req.wr_addr = s3_i_r;
      mem_req.wr_data = mem_rd;
    end else if (s4_v_r && (s4_cmd_r == CMD_WORD)) begin
      mem_req.wr_en   = 1'b1;
      mem_req.wr_addr = s4_j_r;
      mem_req.wr_data = s4_si_r;
    end
  end

  wscx_perm_mem u_perm_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (mem_req),
    .rd_data_r (mem_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r    <= '0;
      j_r    <= '0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s2_v_r <= accept;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      if (accept) begin
        if (in_cmd == CMD_WORD) begin
          i_r <= i_first;
        end else if (in_start_of_buffer) begin
          i_r <= '0;
        end
        if (in_start_of_buffer) begin
          j_r <= '0;
        end
      end else if (s2_v_r && (s2_cmd_r == CMD_WORD)) begin
        j_r <= j_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_cmd_r  <= in_cmd;
    s2_data_r <= in_data_in;
    s2_i_r    <= i_first;

    s3_cmd_r  <= s2_cmd_r;
    s3_data_r <= s2_data_r;
    s3_i_r    <= s2_i_r;
    s3_j_r    <= j_sum;
    s3_si_r   <= mem_rd;

    s4_cmd_r  <= s3_cmd_r;
    s4_data_r <= s3_data_r;
    s4_j_r    <= s3_j_r;
    s4_si_r   <= s3_si_r;
    s4_fwd_r  <= (key_addr == s3_j_r);
  end

  // S[j] takes its swapped value only in the last cycle
  assign keystream = s4_fwd_r ? s4_si_r : mem_rd;

  always_comb begin
    if (s4_cmd_r == CMD_BYTE) begin
      result = {{(WORD_W-BYTE_W){1'b0}}, s4_data_r[BYTE_W-1:0] ^ BYTE_PAD};
    end else begin
      result = s4_data_r ^ keystream;
    end
  end

  assign fifo_pop = out_valid & ~out_stall;

  wscx_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (s4_v_r),
    .push_data  (result),
    .pop        (fifo_pop),
    .head_valid (out_valid),
    .head_data  (out_data_out),
    .count_r    (fifo_count)
  );

endmodule
`default_nettype wire

// ----- src/wscx_perm_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wscx_perm_mem
// Permutation table: one write and one registered read per cycle. Entries
// not written since the last clear read from the scheduled image.
// ----------------------------------------------------------------------------
module wscx_perm_mem import wscx_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire wscx_mem_req_t     req,
  output logic [WORD_W-1:0]      rd_data_r
);

  logic [WORD_W-1:0]        mem_r [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic                     wr_go;

  assign wr_go = req.wr_en & ~req.clear;

  always_ff @(posedge clk) begin
    if (wr_go) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.clear) begin
      valid_r <= '0;
    end else if (wr_go) begin
      valid_r[req.wr_addr] <= 1'b1;
    end
  end

  // bypass a same-cycle write to the read address
  always_ff @(posedge clk) begin
    if (wr_go && (req.wr_addr == req.rd_addr)) begin
      rd_data_r <= req.wr_data;
    end else if (!req.clear && valid_r[req.rd_addr]) begin
      rd_data_r <= mem_r[req.rd_addr];
    end else begin
      rd_data_r <= PERM_ROM[req.rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- src/wscx_out_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wscx_out_fifo
// Two-entry result queue between the cipher pipeline and the output channel.
// ----------------------------------------------------------------------------
module wscx_out_fifo import wscx_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [WORD_W-1:0] push_data,
  input  wire logic              pop,
  output logic                   head_valid,
  output logic [WORD_W-1:0]      head_data,
  output logic [1:0]             count_r
);

  logic [WORD_W-1:0] slot_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        count_nxt;

  assign head_valid = (count_r != 2'd0);
  assign head_data  = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- dv/word_stream_cipher_xor_unit_tb.sv -----
// ----------------------------------------------------------------------------
// word_stream_cipher_xor_unit_tb
// Self-checking bench for the word stream cipher unit. A short table of
// directed requests covers the field extremes, both commands, start of
// buffer on words and on trailing bytes, and the trailing-byte upper bits.
// Random buffers follow, some long enough to wrap the table index. An
// in-bench cipher model predicts the results but for the typed directed bytes,
// and random idling on both channels moves gaps across every phase of a request.
// ----------------------------------------------------------------------------
module word_stream_cipher_xor_unit_tb;
  import wscx_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          N_ENTRIES = 256;
  localparam logic [7:0]  TRAIL_PAD = 8'h8D;
  localparam int          N_RANDOM  = 1100;
  localparam int          N_DIRECTED = 15;

  typedef struct packed {
    logic              cmd;
    logic              sob;
    logic [WORD_W-1:0] data;
    logic              typed;
    logic [WORD_W-1:0] word;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_cmd = CMD_WORD;
  logic              in_start_of_buffer = 1'b0;
  logic [WORD_W-1:0] in_data_in = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [WORD_W-1:0] out_data_out;

  logic              steady = 1'b0;
  int                mismatches = 0;

  logic [31:0]       key_image [N_ENTRIES];
  logic [31:0]       sbox [N_ENTRIES];
  logic [7:0]        idx_i;
  logic [7:0]        idx_j;
  logic [31:0]       pending_words [$];
  dir_row_t          directed_rows [N_DIRECTED];

  word_stream_cipher_xor_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_start_of_buffer (in_start_of_buffer),
    .in_data_in         (in_data_in),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_data_out       (out_data_out)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void reload_cipher();
    sbox  = key_image;
    idx_i = '0;
    idx_j = '0;
  endfunction

  function automatic logic [31:0] cipher_step(input logic cmd, input logic sob,
                                              input logic [31:0] data);
    logic [31:0] si;
    logic [31:0] sj;
    logic [7:0]  ks_idx;
    if (sob) reload_cipher();
    if (cmd == CMD_BYTE) return {24'h0, data[7:0] ^ TRAIL_PAD};
    idx_i        = idx_i + 8'd1;
    idx_j        = idx_j + sbox[idx_i][7:0];
    si           = sbox[idx_i];
    sj           = sbox[idx_j];
    sbox[idx_i]  = sj;
    sbox[idx_j]  = si;
    ks_idx       = si[7:0] + sj[7:0];
    return data ^ sbox[ks_idx];
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  task automatic send_request(input logic cmd, input logic sob, input logic [31:0] data,
                              input logic typed, input logic [31:0] typed_word);
    logic [31:0] predicted;
    while (!steady && $urandom_range(0, 99) < 37) begin
      in_valid   = 1'b0;
      in_data_in = $urandom;
      @(negedge clk);
    end
    in_valid           = 1'b1;
    in_cmd             = cmd;
    in_start_of_buffer = sob;
    in_data_in         = data;
    do @(posedge clk); while (in_stall);
    predicted = cipher_step(cmd, sob, data);
    pending_words.push_back(typed ? typed_word : predicted);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 37);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("result %08h with no request waiting", out_data_out));
      end else begin
        if (out_data_out !== pending_words[0])
          report_mismatch($sformatf("data_out %08h, expected %08h",
                                    out_data_out, pending_words[0]));
        void'(pending_words.pop_front());
      end
    end
  end

  initial begin
    logic [31:0] sched_key [16];
    logic [31:0] tmp;
    logic [31:0] divisor;
    logic [7:0]  jj;
    int          sent;
    int          blen;
    int          nbytes;

    sched_key = '{
      32'hFFAA_FFAA, 32'hAAFC_AAFC, 32'hA37E_A37E, 32'hB34E_B34E,
      32'hFFFF_FFFF, 32'h3BE7_3BE7, 32'hCBA9_CBA9, 32'h23C1_23C1,
      32'h2E6C_2E6C, 32'h13CB_13CB, 32'h64E7_64E7, 32'h34D2_34D2,
      32'hFF6C_2E6C, 32'h13FF_13CB, 32'h64E7_FFE7, 32'h34D2_34FF
    };
    for (int k = 0; k < N_ENTRIES; k++) begin
      divisor      = k + 1;
      key_image[k] = 32'hFFFF_FFFF / divisor;
    end
    jj = '0;
    for (int k = 0; k < N_ENTRIES; k++) begin
      jj            = jj + key_image[k][7:0] + sched_key[k % 16][7:0];
      tmp           = key_image[k];
      key_image[k]  = key_image[jj];
      key_image[jj] = tmp;
    end

    directed_rows = '{
      '{CMD_WORD, 1'b0, 32'h0000_0000, 1'b0, 32'h0},
      '{CMD_WORD, 1'b0, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{CMD_WORD, 1'b0, 32'h1234_5678, 1'b0, 32'h0},
      '{CMD_BYTE, 1'b0, 32'h0000_0000, 1'b1, 32'h0000_008D},
      '{CMD_BYTE, 1'b0, 32'hFFFF_FFFF, 1'b1, 32'h0000_0072},
      '{CMD_BYTE, 1'b0, 32'hFFFF_FF8D, 1'b1, 32'h0000_0000},
      '{CMD_BYTE, 1'b0, 32'h1234_5672, 1'b1, 32'h0000_00FF},
      '{CMD_WORD, 1'b1, 32'h0000_0000, 1'b0, 32'h0},
      '{CMD_WORD, 1'b0, 32'hA5A5_A5A5, 1'b0, 32'h0},
      '{CMD_BYTE, 1'b1, 32'h0000_00AA, 1'b1, 32'h0000_0027},
      '{CMD_WORD, 1'b0, 32'h0000_0000, 1'b0, 32'h0},
      '{CMD_WORD, 1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{CMD_WORD, 1'b0, 32'h8000_0001, 1'b0, 32'h0},
      '{CMD_WORD, 1'b0, 32'h0000_0001, 1'b0, 32'h0},
      '{CMD_BYTE, 1'b0, 32'hFFFF_FF5A, 1'b1, 32'h0000_00D7}
    };

    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    reload_cipher();

    for (int r = 0; r < N_DIRECTED; r++)
      send_request(directed_rows[r].cmd, directed_rows[r].sob, directed_rows[r].data,
                   directed_rows[r].typed, directed_rows[r].word);

    sent = 0;
    while (sent < N_RANDOM) begin
      blen = ($urandom_range(0, 7) == 0) ? $urandom_range(256, 320) : $urandom_range(1, 40);
      for (int w = 0; w < blen && sent < N_RANDOM; w++) begin
        steady = (sent >= 500 && sent < 700);
        if ($urandom_range(0, 9) == 0)
          send_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rand_word(),
                       1'b0, '0);
        else
          send_request(CMD_WORD, w == 0, rand_word(), 1'b0, '0);
        sent++;
      end
      nbytes = $urandom_range(0, 3);
      for (int b = 0; b < nbytes && sent < N_RANDOM; b++) begin
        send_request(CMD_BYTE, 1'b0, rand_word(), 1'b0, '0);
        sent++;
      end
    end
    in_valid = 1'b0;
    steady   = 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0) begin
      $display("word_stream_cipher_xor_unit_tb passed");
    end else begin
      $display("word_stream_cipher_xor_unit_tb failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("word_stream_cipher_xor_unit_tb failed");
    $finish;
  end

endmodule

// ----- sim.f -----
src/wscx_pkg.sv
src/wscx_perm_mem.sv
src/wscx_out_fifo.sv
src/word_stream_cipher_xor_unit.sv
dv/word_stream_cipher_xor_unit_tb.sv
